>>> hw/rtl/rotate_vector_to_normal_frame_assert.svh
// Assertion macros for the block's modules; rvnf_back includes them.
// Each macro expects signals named clock and reset in the using scope.
`ifndef ROTATE_VECTOR_TO_NORMAL_FRAME_ASSERT_SVH
`define ROTATE_VECTOR_TO_NORMAL_FRAME_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RVNF_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) cond) else $error(msg);

// A condition in one cycle implies a condition in the next cycle.
`define RVNF_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

>>> hw/rtl/rvnf_pkg.sv
`timescale 1ns / 1ps

package rvnf_pkg;

   // Field formats.
   localparam int VEC_WIDTH      = 32;
   localparam int NORM_FRAC_BITS = 30;
   localparam int NORM_WIDTH     = NORM_FRAC_BITS + 2;

   // Internal widths.
   localparam int NUM_WIDTH  = 2 * NORM_WIDTH;
   localparam int QUO_BITS   = NORM_FRAC_BITS + 3;
   localparam int CSUM_WIDTH = QUO_BITS + 2;
   localparam int PROD_WIDTH = NORM_WIDTH + VEC_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int NUM_COEF   = 9;

   typedef logic signed [VEC_WIDTH-1:0]  vec_type;
   typedef logic signed [NORM_WIDTH-1:0] norm_type;
   typedef logic [NORM_WIDTH-1:0]        mag_type;
   typedef logic [NUM_WIDTH-1:0]         num_type;
   typedef logic [QUO_BITS-1:0]          quo_type;

   localparam norm_type NORM_ONE = {2'b01, {NORM_FRAC_BITS{1'b0}}};
   localparam norm_type NORM_MAX = {1'b0, {(NORM_WIDTH-1){1'b1}}};
   localparam norm_type NORM_MIN = {1'b1, {(NORM_WIDTH-1){1'b0}}};
   localparam vec_type  VEC_MAX  = {1'b0, {(VEC_WIDTH-1){1'b1}}};
   localparam vec_type  VEC_MIN  = {1'b1, {(VEC_WIDTH-1){1'b0}}};
   localparam quo_type  QUO_CAP  = {1'b1, {(QUO_BITS-1){1'b0}}};

   // Data that travels alongside an item through the pipeline.
   typedef struct packed {
      vec_type  vel_x;
      vec_type  vel_y;
      vec_type  vel_z;
      norm_type n0;
      norm_type n1;
      norm_type c;
      logic     neg_w;
      logic     bypass;
   } side_type;

   typedef struct packed {
      vec_type val;
      logic    clip;
   } rsat_type;

   // Saturate a widened coefficient to the Q2.30 range.
   function automatic norm_type coef_sat(input logic signed [CSUM_WIDTH-1:0] x);
      logic signed [CSUM_WIDTH-1:0] hi;
      logic signed [CSUM_WIDTH-1:0] lo;
      hi = {{(CSUM_WIDTH-NORM_WIDTH+1){1'b0}}, {(NORM_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (x > hi) begin
         return NORM_MAX;
      end else if (x < lo) begin
         return NORM_MIN;
      end
      return x[NORM_WIDTH-1:0];
   endfunction

   // Round a row sum half up to Q16.16 and saturate it.
   function automatic rsat_type round_sat(input logic signed [SUM_WIDTH-1:0] s);
      logic signed [SUM_WIDTH-1:0] half;
      logic signed [SUM_WIDTH-1:0] r;
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      rsat_type                    res;
      half = $signed({{(SUM_WIDTH-NORM_FRAC_BITS){1'b0}}, 1'b1,
                      {(NORM_FRAC_BITS-1){1'b0}}});
      hi   = {{(SUM_WIDTH-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
      lo   = ~hi;
      r    = (s + half) >>> NORM_FRAC_BITS;
      if (r > hi) begin
         res.val  = VEC_MAX;
         res.clip = 1'b1;
      end else if (r < lo) begin
         res.val  = VEC_MIN;
         res.clip = 1'b1;
      end else begin
         res.val  = r[VEC_WIDTH-1:0];
         res.clip = 1'b0;
      end
      return res;
   endfunction

endpackage

>>> hw/rtl/rotate_vector_to_normal_frame.sv
`timescale 1ns / 1ps

// Rotates a Q16.16 velocity vector so that the z axis maps onto a Q2.30 unit
// normal, saturating each result component to the Q16.16 range.
// Input channel req_*: one item carries the velocity and the normal. Result
// channel rsp_*: one item per input item, in order, with a saturated flag.
// Both channels use valid and ready; an item moves when both are high.
// Throughput: one item per cycle while the output is not stalled. An item
// passes two operand stages, one rounding stage ahead of the divider, the
// 33-stage restoring divider that forms the three quotient terms and four
// stages for coefficients, products, sums and rounding.
// The whole pipeline advances as one: while rsp_valid is high and rsp_ready
// is low every stage holds and req_ready is low, so nothing is lost or
// repeated. A normal with z at or beyond plus or minus one passes the
// velocity through unchanged with saturated low.
// Reset is synchronous and clears all valid bits; no item is in flight after.
module rotate_vector_to_normal_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rvnf_pkg::vec_type   req_vel_x,
   input  rvnf_pkg::vec_type   req_vel_y,
   input  rvnf_pkg::vec_type   req_vel_z,
   input  rvnf_pkg::norm_type  req_norm_x,
   input  rvnf_pkg::norm_type  req_norm_y,
   input  rvnf_pkg::norm_type  req_norm_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rvnf_pkg::vec_type   rsp_rot_x,
   output rvnf_pkg::vec_type   rsp_rot_y,
   output rvnf_pkg::vec_type   rsp_rot_z,
   output logic                rsp_saturated
);

   logic                                en;
   logic                                fr_valid;
   rvnf_pkg::side_type                  fr_side;
   logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] fr_num;
   rvnf_pkg::mag_type                   fr_den;
   logic                                dv_valid;
   rvnf_pkg::side_type                  dv_side;
   logic [2:0][rvnf_pkg::QUO_BITS-1:0]  dv_quo;
   logic [2:0]                          dv_ovf;

   // The pipeline moves whenever the output register is empty or being taken.
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   rvnf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .vel_z     (req_vel_z),
      .norm_x    (req_norm_x),
      .norm_y    (req_norm_y),
      .norm_z    (req_norm_z),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_num   (fr_num),
      .out_den   (fr_den)
   );

   rvnf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf)
   );

   rvnf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_quo    (dv_quo),
      .in_ovf    (dv_ovf),
      .out_valid (rsp_valid),
      .rot_x     (rsp_rot_x),
      .rot_y     (rsp_rot_y),
      .rot_z     (rsp_rot_z),
      .saturated (rsp_saturated)
   );

endmodule

>>> hw/rtl/rvnf_front.sv
`timescale 1ns / 1ps

module rvnf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rvnf_pkg::vec_type          vel_x,
   input  rvnf_pkg::vec_type          vel_y,
   input  rvnf_pkg::vec_type          vel_z,
   input  rvnf_pkg::norm_type         norm_x,
   input  rvnf_pkg::norm_type         norm_y,
   input  rvnf_pkg::norm_type         norm_z,
   output logic                       out_valid,
   output rvnf_pkg::side_type         out_side,
   output logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] out_num,
   output rvnf_pkg::mag_type          out_den
);

   logic               a_valid_ff;
   rvnf_pkg::side_type a_side_ff, a_side_in;
   rvnf_pkg::mag_type  a_mag0_ff, a_mag0_in;
   rvnf_pkg::mag_type  a_mag1_ff, a_mag1_in;
   rvnf_pkg::mag_type  a_den_ff, a_den_in;

   logic               b_valid_ff;
   rvnf_pkg::side_type b_side_ff;
   rvnf_pkg::mag_type  b_den_ff;
   logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] b_num_ff, b_num_in;

   // Operand preparation: magnitudes, denominator and the vertical-normal check.
   always_comb begin
      a_side_in.vel_x  = vel_x;
      a_side_in.vel_y  = vel_y;
      a_side_in.vel_z  = vel_z;
      a_side_in.n0     = norm_x;
      a_side_in.n1     = norm_y;
      a_side_in.c      = norm_z;
      a_side_in.neg_w  = (norm_x[rvnf_pkg::NORM_WIDTH-1] == norm_y[rvnf_pkg::NORM_WIDTH-1]);
      a_side_in.bypass = (norm_z >= rvnf_pkg::NORM_ONE) || (norm_z <= -rvnf_pkg::NORM_ONE);
      a_mag0_in = norm_x[rvnf_pkg::NORM_WIDTH-1] ? rvnf_pkg::mag_type'(-norm_x)
                                                 : rvnf_pkg::mag_type'(norm_x);
      a_mag1_in = norm_y[rvnf_pkg::NORM_WIDTH-1] ? rvnf_pkg::mag_type'(-norm_y)
                                                 : rvnf_pkg::mag_type'(norm_y);
      a_den_in  = rvnf_pkg::mag_type'(rvnf_pkg::NORM_ONE + norm_z);
   end

   // Squares and cross product of the magnitudes.
   always_comb begin
      b_num_in[0] = rvnf_pkg::NUM_WIDTH'(a_mag1_ff) * rvnf_pkg::NUM_WIDTH'(a_mag1_ff);
      b_num_in[1] = rvnf_pkg::NUM_WIDTH'(a_mag0_ff) * rvnf_pkg::NUM_WIDTH'(a_mag0_ff);
      b_num_in[2] = rvnf_pkg::NUM_WIDTH'(a_mag0_ff) * rvnf_pkg::NUM_WIDTH'(a_mag1_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         a_mag0_ff <= a_mag0_in;
         a_mag1_ff <= a_mag1_in;
         a_den_ff  <= a_den_in;
         b_side_ff <= a_side_ff;
         b_den_ff  <= a_den_ff;
         b_num_ff  <= b_num_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_side  = b_side_ff;
   assign out_num   = b_num_ff;
   assign out_den   = b_den_ff;

endmodule

>>> hw/rtl/rvnf_div.sv
`timescale 1ns / 1ps

module rvnf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rvnf_pkg::side_type         in_side,
   input  logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] in_num,
   input  rvnf_pkg::mag_type          in_den,
   output logic                       out_valid,
   output rvnf_pkg::side_type         out_side,
   output logic [2:0][rvnf_pkg::QUO_BITS-1:0] out_quo,
   output logic [2:0]                 out_ovf
);

   logic               st_valid_ff [0:rvnf_pkg::QUO_BITS];
   rvnf_pkg::side_type st_side_ff  [0:rvnf_pkg::QUO_BITS];
   rvnf_pkg::mag_type  st_den_ff   [0:rvnf_pkg::QUO_BITS];
   logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] st_rem_ff [0:rvnf_pkg::QUO_BITS];
   logic [2:0][rvnf_pkg::QUO_BITS-1:0]  st_quo_ff [0:rvnf_pkg::QUO_BITS];
   logic [2:0]         st_ovf_ff   [0:rvnf_pkg::QUO_BITS];

   logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] pre_rem_in;
   logic [2:0]                          pre_ovf_in;

   // Add half the denominator for rounding and flag quotients beyond the
   // quotient width, which are capped later.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pre_rem_in[j] = in_num[j] + rvnf_pkg::NUM_WIDTH'(in_den >> 1);
         pre_ovf_in[j] = (pre_rem_in[j] >> rvnf_pkg::QUO_BITS) >=
                         rvnf_pkg::NUM_WIDTH'(in_den);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff[0] <= 1'b0;
      end else if (en) begin
         st_valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_side_ff[0] <= in_side;
         st_den_ff[0]  <= in_den;
         st_rem_ff[0]  <= pre_rem_in;
         st_quo_ff[0]  <= '0;
         st_ovf_ff[0]  <= pre_ovf_in;
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar s = 0; s < rvnf_pkg::QUO_BITS; s++) begin : g_step
      localparam int K = rvnf_pkg::QUO_BITS - 1 - s;
      logic [2:0][rvnf_pkg::NUM_WIDTH-1:0] rem_in;
      logic [2:0][rvnf_pkg::QUO_BITS-1:0]  quo_in;
      logic [rvnf_pkg::NUM_WIDTH-1:0]      dsh;

      always_comb begin
         dsh = rvnf_pkg::NUM_WIDTH'(st_den_ff[s]) << K;
         for (int j = 0; j < 3; j++) begin
            if (st_rem_ff[s][j] >= dsh) begin
               rem_in[j] = st_rem_ff[s][j] - dsh;
               quo_in[j] = st_quo_ff[s][j] | (rvnf_pkg::quo_type'(1) << K);
            end else begin
               rem_in[j] = st_rem_ff[s][j];
               quo_in[j] = st_quo_ff[s][j];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[s+1] <= 1'b0;
         end else if (en) begin
            st_valid_ff[s+1] <= st_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_side_ff[s+1] <= st_side_ff[s];
            st_den_ff[s+1]  <= st_den_ff[s];
            st_rem_ff[s+1]  <= rem_in;
            st_quo_ff[s+1]  <= quo_in;
            st_ovf_ff[s+1]  <= st_ovf_ff[s];
         end
      end
   end

   assign out_valid = st_valid_ff[rvnf_pkg::QUO_BITS];
   assign out_side  = st_side_ff[rvnf_pkg::QUO_BITS];
   assign out_quo   = st_quo_ff[rvnf_pkg::QUO_BITS];
   assign out_ovf   = st_ovf_ff[rvnf_pkg::QUO_BITS];

endmodule

>>> hw/rtl/rvnf_back.sv
`timescale 1ns / 1ps

module rvnf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  rvnf_pkg::side_type         in_side,
   input  logic [2:0][rvnf_pkg::QUO_BITS-1:0] in_quo,
   input  logic [2:0]                 in_ovf,
   output logic                       out_valid,
   output rvnf_pkg::vec_type          rot_x,
   output rvnf_pkg::vec_type          rot_y,
   output rvnf_pkg::vec_type          rot_z,
   output logic                       saturated
);

   logic                                 c1_valid_ff;
   rvnf_pkg::side_type                   c1_side_ff;
   rvnf_pkg::norm_type                   c1_coef_ff [rvnf_pkg::NUM_COEF];
   rvnf_pkg::norm_type                   c1_coef_in [rvnf_pkg::NUM_COEF];
   rvnf_pkg::quo_type                    tq [3];
   logic signed [rvnf_pkg::CSUM_WIDTH-1:0] qs [3];
   logic signed [rvnf_pkg::CSUM_WIDTH-1:0] cw;

   logic                                 c2_valid_ff;
   rvnf_pkg::side_type                   c2_side_ff;
   logic signed [rvnf_pkg::PROD_WIDTH-1:0] c2_prod_ff [rvnf_pkg::NUM_COEF];
   logic signed [rvnf_pkg::PROD_WIDTH-1:0] c2_prod_in [rvnf_pkg::NUM_COEF];
   rvnf_pkg::vec_type                    vel [3];

   logic                                 c3_valid_ff;
   rvnf_pkg::side_type                   c3_side_ff;
   logic signed [rvnf_pkg::SUM_WIDTH-1:0] c3_sum_ff [3];
   logic signed [rvnf_pkg::SUM_WIDTH-1:0] c3_sum_in [3];

   rvnf_pkg::rsat_type                   rs [3];
   rvnf_pkg::vec_type                    rot_x_in, rot_y_in, rot_z_in;
   logic                                 sat_in;
   logic                                 out_valid_ff;
   rvnf_pkg::vec_type                    rot_x_ff, rot_y_ff, rot_z_ff;
   logic                                 sat_ff;

   logic                                 out_at_limit;
   logic                                 neg_coef_ok;
   logic [3:0]                           valid_vec;

   // Rotation matrix coefficients, row by row.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         tq[j] = (in_ovf[j] || (in_quo[j] > rvnf_pkg::QUO_CAP)) ? rvnf_pkg::QUO_CAP
                                                              : in_quo[j];
         qs[j] = $signed({2'b00, tq[j]});
      end
      cw = rvnf_pkg::CSUM_WIDTH'(in_side.c);
      c1_coef_in[0] = rvnf_pkg::coef_sat(cw + qs[0]);
      c1_coef_in[1] = rvnf_pkg::coef_sat(in_side.neg_w ? -qs[2] : qs[2]);
      c1_coef_in[2] = in_side.n0;
      c1_coef_in[3] = c1_coef_in[1];
      c1_coef_in[4] = rvnf_pkg::coef_sat(cw + qs[1]);
      c1_coef_in[5] = in_side.n1;
      c1_coef_in[6] = rvnf_pkg::coef_sat(-rvnf_pkg::CSUM_WIDTH'(in_side.n0));
      c1_coef_in[7] = rvnf_pkg::coef_sat(-rvnf_pkg::CSUM_WIDTH'(in_side.n1));
      c1_coef_in[8] = in_side.c;
   end

   // Nine coefficient by velocity products.
   always_comb begin
      vel[0] = c1_side_ff.vel_x;
      vel[1] = c1_side_ff.vel_y;
      vel[2] = c1_side_ff.vel_z;
      for (int i = 0; i < rvnf_pkg::NUM_COEF; i++) begin
         c2_prod_in[i] = rvnf_pkg::PROD_WIDTH'(c1_coef_ff[i]) *
                         rvnf_pkg::PROD_WIDTH'(vel[i % 3]);
      end
   end

   // Exact row sums.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         c3_sum_in[r] = rvnf_pkg::SUM_WIDTH'(c2_prod_ff[3*r]) +
                        rvnf_pkg::SUM_WIDTH'(c2_prod_ff[3*r+1]) +
                        rvnf_pkg::SUM_WIDTH'(c2_prod_ff[3*r+2]);
      end
   end

   // Rounding, saturation and the vertical-normal pass-through.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rs[r] = rvnf_pkg::round_sat(c3_sum_ff[r]);
      end
      if (c3_side_ff.bypass) begin
         rot_x_in = c3_side_ff.vel_x;
         rot_y_in = c3_side_ff.vel_y;
         rot_z_in = c3_side_ff.vel_z;
         sat_in   = 1'b0;
      end else begin
         rot_x_in = rs[0].val;
         rot_y_in = rs[1].val;
         rot_z_in = rs[2].val;
         sat_in   = rs[0].clip | rs[1].clip | rs[2].clip;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         c3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         c1_valid_ff  <= in_valid;
         c2_valid_ff  <= c1_valid_ff;
         c3_valid_ff  <= c2_valid_ff;
         out_valid_ff <= c3_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         c1_side_ff <= in_side;
         c1_coef_ff <= c1_coef_in;
         c2_side_ff <= c1_side_ff;
         c2_prod_ff <= c2_prod_in;
         c3_side_ff <= c2_side_ff;
         c3_sum_ff  <= c3_sum_in;
         rot_x_ff   <= rot_x_in;
         rot_y_ff   <= rot_y_in;
         rot_z_ff   <= rot_z_in;
         sat_ff     <= sat_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign rot_x     = rot_x_ff;
   assign rot_y     = rot_y_ff;
   assign rot_z     = rot_z_ff;
   assign saturated = sat_ff;

   // Helper terms for the checks below.
   assign out_at_limit = (rot_x_ff == rvnf_pkg::VEC_MAX) || (rot_x_ff == rvnf_pkg::VEC_MIN) ||
                         (rot_y_ff == rvnf_pkg::VEC_MAX) || (rot_y_ff == rvnf_pkg::VEC_MIN) ||
                         (rot_z_ff == rvnf_pkg::VEC_MAX) || (rot_z_ff == rvnf_pkg::VEC_MIN);
   assign neg_coef_ok  = (c1_coef_ff[6] != rvnf_pkg::NORM_MIN) &&
                         (c1_coef_ff[7] != rvnf_pkg::NORM_MIN);
   assign valid_vec    = {c1_valid_ff, c2_valid_ff, c3_valid_ff, out_valid_ff};

`include "rotate_vector_to_normal_frame_assert.svh"

   // A clipped item has at least one component at a range limit.
`RVNF_ASSERT(a_sat_at_limit, out_valid_ff && sat_ff |-> out_at_limit, "saturated item without a clipped component")
   // The negated normal terms never reach the most negative code.
`RVNF_ASSERT(a_neg_coef, c1_valid_ff |-> neg_coef_ok, "negated normal term not saturated")
   // A stalled pipeline keeps its valid bits in place.
`RVNF_ASSERT_NEXT(a_stall_hold, !en, $stable(valid_vec), "valid bit moved during a stall")

endmodule
